// ===== rtl/cfr8_pkg.sv =====
// ----------------------------------------------------------------------------
// cfr8_pkg: shared types and constants for the command frame receiver
// Frame layout, register indexes, status codes and the CRC-8 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr8_pkg;

    localparam int MAX_PAYLOAD    = 16;
    localparam int FRAME_OVERHEAD = 4;

    localparam int LEN_W   = $clog2(MAX_PAYLOAD + 1);                  // saturated length
    localparam int IDX_W   = $clog2(MAX_PAYLOAD);                      // payload index
    localparam int POS_W   = $clog2(MAX_PAYLOAD + FRAME_OVERHEAD);     // frame position
    localparam int CFG_W   = 8;
    localparam int CIDX_W  = 2;

    localparam logic [7:0] CRC_POLY = 8'h8C;

    // frame positions of the fixed bytes
    localparam logic [POS_W-1:0] POS_LENGTH   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_COMMAND  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CHECKSUM = POS_W'(3);
    localparam logic [POS_W-1:0] POS_PAYLOAD  = POS_W'(FRAME_OVERHEAD);

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_PAYLOAD_LEN = 2'd0;
    localparam logic [CIDX_W-1:0] REG_UNSUPPORTED = 2'd1;
    localparam logic [CIDX_W-1:0] REG_CONFLICT    = 2'd2;
    localparam logic [CIDX_W-1:0] REG_BAD_PARAM   = 2'd3;

    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_CHECKSUM    = 3'd1,
        STATUS_UNSUPPORTED = 3'd2,
        STATUS_LENGTH      = 3'd3,
        STATUS_CONFLICT    = 3'd4,
        STATUS_BAD_PARAM   = 3'd5
    } status_t;

    // reflected CRC-8, one byte, no final xor
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/command_frame_receiver_crc8.sv =====
// ----------------------------------------------------------------------------
// command_frame_receiver_crc8: CRC-8 checked command frame receiver
// Takes a reply frame byte by byte, checks it and streams out one result
// per payload byte (or one result for an acknowledge frame).
// ----------------------------------------------------------------------------
// Throughput: one byte accepted per cycle outside the stall below; results leave
//   at one per cycle while m_tready is high. A frame's first result passes
//   through the descriptor, which loads with the frame's final byte, and then
//   through the output register.
// The input stalls only when a byte sits where the frame would end while the
//   previous frame's results are still being moved into the output register.
// Reset (rst_n low, async): frame state, CRC and registers to defaults; no results.
`default_nettype none

module command_frame_receiver_crc8 (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration write port
    input  wire logic                        cfg_we,
    input  wire logic [cfr8_pkg::CIDX_W-1:0] cfg_index,
    input  wire logic [cfr8_pkg::CFG_W-1:0]  cfg_data,
    // received byte requests
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // [7:0] rx_byte
    input  wire logic                        s_tuser,   // [0] restart
    // result requests
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [23:0]                      m_tdata,   // [7:0] command, [10:8] status,
                                                        // [18:11] payload_byte,
                                                        // [22:19] byte_index, [23] zero
    output logic                             m_tuser,   // [0] has_payload
    output logic                             m_tlast    // last result of the frame
);
    import cfr8_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [4:0] len_cfg_reg;
    logic [7:0] unsup_code_reg;
    logic [7:0] conflict_code_reg;
    logic [7:0] bad_param_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg        <= '0;
            unsup_code_reg     <= 8'd1;
            conflict_code_reg  <= 8'd2;
            bad_param_code_reg <= 8'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PAYLOAD_LEN: len_cfg_reg        <= cfg_data[4:0];
                REG_UNSUPPORTED: unsup_code_reg     <= cfg_data;
                REG_CONFLICT:    conflict_code_reg  <= cfg_data;
                REG_BAD_PARAM:   bad_param_code_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Length above the store size saturates.
    logic [LEN_W-1:0] len_sat;
    assign len_sat = (32'(len_cfg_reg) > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD)
                                                      : LEN_W'(len_cfg_reg);

    // frame end compare is done one bit wider than the position
    logic [POS_W:0] frame_len;
    assign frame_len = (POS_W+1)'(len_sat) + (POS_W+1)'(FRAME_OVERHEAD);

    // ------------------------------------------------------------------
    // Frame assembly state
    // ------------------------------------------------------------------
    logic [POS_W-1:0] pos_reg,      pos_next;
    logic [7:0]       crc_reg,      crc_next;
    logic [7:0]       length_reg,   length_next;
    logic [7:0]       command_reg,  command_next;
    logic [7:0]       checksum_reg, checksum_next;
    logic             wr_bank_reg,  wr_bank_next;

    // Two payload banks: one fills while the other drains to the output.
    logic [7:0] payload_mem [2][MAX_PAYLOAD];

    // Frame descriptor handed to the output side
    logic             desc_busy_reg,   desc_busy_next;
    logic             desc_bank_reg;
    logic [IDX_W-1:0] desc_idx_reg,    desc_idx_next;
    logic [LEN_W-1:0] desc_len_reg;
    logic [7:0]       desc_cmd_reg;
    status_t          desc_status_reg;

    // Output register
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_cmd_reg;
    status_t          out_status_reg;
    logic [7:0]       out_payload_reg;
    logic [IDX_W-1:0] out_index_reg;
    logic             out_has_reg;
    logic             out_last_reg;

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    logic             near_end;
    logic             in_fire;
    logic             restart;
    logic [7:0]       rx_byte;
    logic [POS_W-1:0] pos_base;
    logic [7:0]       crc_base;
    logic             frame_done;
    logic             pay_wr;
    logic [IDX_W-1:0] pay_wr_addr;
    logic [POS_W-1:0] pay_off;
    status_t          status_new;

    assign rx_byte = s_tdata;
    assign restart = s_tuser;

    // The next byte could finish a frame (a restart never does, so it is
    // ignored here to keep ready off the data). Hold it while the previous
    // descriptor is still draining.
    assign near_end = ((POS_W+1)'(pos_reg) + 1'b1) >= frame_len;
    assign s_tready = !(desc_busy_reg && near_end);
    assign in_fire  = s_tvalid && s_tready;

    assign pos_base = restart ? '0 : pos_reg;
    assign crc_base = restart ? '0 : crc_reg;
    assign pay_off  = pos_base - POS_PAYLOAD;

    always_comb
    begin
        length_next   = length_reg;
        command_next  = command_reg;
        checksum_next = checksum_reg;
        crc_next      = crc_base;
        pay_wr        = 1'b0;
        pay_wr_addr   = pay_off[IDX_W-1:0];

        if (pos_base == POS_CHECKSUM)
        begin
            checksum_next = rx_byte;
        end
        else
        begin
            if (pos_base == POS_LENGTH)
                length_next = rx_byte;
            else if (pos_base == POS_COMMAND)
                command_next = rx_byte;
            else if (pos_base >= POS_PAYLOAD && 32'(pay_off) < MAX_PAYLOAD)
                pay_wr = 1'b1;
            crc_next = crc8_byte(crc_base, rx_byte);
        end
    end

    assign frame_done = ((POS_W+1)'(pos_base) + 1'b1) >= frame_len;

    // Status priority differs between payload and acknowledge frames.
    always_comb
    begin
        if (len_sat != '0)
        begin
            if (checksum_next != crc_next)
                status_new = STATUS_CHECKSUM;
            else if (command_next == unsup_code_reg)
                status_new = STATUS_UNSUPPORTED;
            else if (length_next != 8'(len_sat))
                status_new = STATUS_LENGTH;
            else
                status_new = STATUS_OK;
        end
        else
        begin
            if (checksum_next != crc_next || length_next != 8'd0)
                status_new = STATUS_CHECKSUM;
            else if (command_next == conflict_code_reg)
                status_new = STATUS_CONFLICT;
            else if (command_next == unsup_code_reg)
                status_new = STATUS_UNSUPPORTED;
            else if (command_next == bad_param_code_reg)
                status_new = STATUS_BAD_PARAM;
            else
                status_new = STATUS_OK;
        end
    end

    always_comb
    begin
        pos_next     = pos_reg;
        wr_bank_next = wr_bank_reg;
        if (in_fire)
        begin
            if (frame_done)
            begin
                pos_next     = '0;
                wr_bank_next = !wr_bank_reg;
            end
            else
            begin
                pos_next = pos_base + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            crc_reg      <= '0;
            length_reg   <= '0;
            command_reg  <= '0;
            checksum_reg <= '0;
            wr_bank_reg  <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            wr_bank_reg <= wr_bank_next;
            if (in_fire)
            begin
                crc_reg      <= frame_done ? '0 : crc_next;
                length_reg   <= length_next;
                command_reg  <= command_next;
                checksum_reg <= checksum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && pay_wr)
            payload_mem[wr_bank_reg][pay_wr_addr] <= rx_byte;
    end

    // ------------------------------------------------------------------
    // Output side: descriptor walks its payload into the output register
    // ------------------------------------------------------------------
    logic out_load;
    logic desc_has;
    logic desc_last;

    assign out_load  = desc_busy_reg && (!out_valid_reg || m_tready);
    assign desc_has  = (desc_len_reg != '0);
    assign desc_last = !desc_has || (LEN_W'(desc_idx_reg) + 1'b1 == desc_len_reg);

    always_comb
    begin
        desc_busy_next = desc_busy_reg;
        desc_idx_next  = desc_idx_reg;
        if (in_fire && frame_done)
        begin
            desc_busy_next = 1'b1;
            desc_idx_next  = '0;
        end
        else if (out_load)
        begin
            if (desc_last)
                desc_busy_next = 1'b0;
            else
                desc_idx_next = desc_idx_reg + 1'b1;
        end

        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_busy_reg <= 1'b0;
            desc_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            desc_busy_reg <= desc_busy_next;
            desc_idx_reg  <= desc_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && frame_done)
        begin
            desc_bank_reg   <= wr_bank_reg;
            desc_len_reg    <= len_sat;
            desc_cmd_reg    <= command_next;
            desc_status_reg <= status_new;
        end
        if (out_load)
        begin
            out_cmd_reg     <= desc_cmd_reg;
            out_status_reg  <= desc_status_reg;
            out_payload_reg <= desc_has ? payload_mem[desc_bank_reg][desc_idx_reg] : 8'd0;
            out_index_reg   <= desc_has ? desc_idx_reg : '0;
            out_has_reg     <= desc_has;
            out_last_reg    <= desc_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_index_reg, out_payload_reg, out_status_reg, out_cmd_reg};
    assign m_tuser  = out_has_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/cfr8_checker.sv =====
// ----------------------------------------------------------------------------
// cfr8_checker: port-level checks for the command frame receiver
// Watches the result stream and flags malformed or broken frames.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr8_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);
    import cfr8_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // status is always a defined code, pad bit clear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[10:8] <= 3'(STATUS_BAD_PARAM)) && !m_tdata[23])
        else $error("bad status code or pad bit");

    // acknowledge result: single, last, zero payload and index
    a_ack_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata[22:11] == 12'd0))
        else $error("acknowledge result malformed");

    // the rest of a frame follows without gaps
    a_frame_burst: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser)
        else $error("gap inside a frame's results");

endmodule

bind command_frame_receiver_crc8 cfr8_checker u_cfr8_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for command_frame_receiver_crc8
// Streams reply frames in byte by byte, both good and broken. A local frame
// decoder predicts every result, and the output stream is checked against
// it field by field. Both sides idle at random, and the output side holds
// off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import cfr8_pkg::*;

    localparam int TIMEOUT_UNITS = 400000;    // hard stop time, far above a slow clean run
    localparam int HOLD_CYCLES   = 400;       // long output hold-off
    localparam int DRAIN_CYCLES  = 8;         // settle time in wait_idle after the last result

    // one byte request on the input stream
    typedef struct {
        logic [7:0] data;
        logic       restart;
    } rx_request_t;

    // one result request on the output stream
    typedef struct {
        logic [7:0]       command;
        status_t          status;
        logic [7:0]       payload;
        logic [IDX_W-1:0] index;
        logic             has_payload;
        logic             last;
    } frame_result_t;

    typedef enum int {
        FRAME_GOOD    = 0,
        FRAME_BAD_SUM = 1,
        FRAME_BAD_LEN = 2,
        FRAME_CUT     = 3,
        FRAME_NOISE   = 4
    } frame_kind_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [CIDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data  = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = '0;
    logic               s_tuser   = 1'b0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [23:0]        m_tdata;
    logic               m_tuser;
    logic               m_tlast;

    command_frame_receiver_crc8 i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [7:0] rx_byte
        .s_tuser   (s_tuser),     // [0] restart
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [7:0] command, [10:8] status, [18:11] payload_byte,
                                  // [22:19] byte_index, [23] zero
        .m_tuser   (m_tuser),     // [0] has_payload
        .m_tlast   (m_tlast)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------
    rx_request_t   byte_queue [$];     // bytes waiting for the driver
    frame_result_t results_due [$];    // predicted results, oldest first
    int unsigned   bytes_queued = 0;
    int unsigned   bytes_taken  = 0;
    int unsigned   error_count  = 0;

    int            tx_idle_max = 0;    // per-request gap ranges, set per phase
    int            rx_idle_max = 0;
    int            tx_wait     = 0;
    int            rx_wait     = 0;
    logic          rx_stall    = 1'b0; // long hold-off, owned by its own process
    logic          hold_go     = 1'b0;
    rx_request_t   next_req;

    // local copy of the registers
    logic [4:0]    len_reg    = 5'd0;
    logic [7:0]    unsup_reg  = 8'd1;
    logic [7:0]    confl_reg  = 8'd2;
    logic [7:0]    badpar_reg = 8'd3;

    // local copy of the frame decoder state
    int unsigned   frame_pos = 0;
    logic [7:0]    frame_crc = 8'h00;
    logic [7:0]    len_byte  = 8'h00;
    logic [7:0]    cmd_byte  = 8'h00;
    logic [7:0]    sum_byte  = 8'h00;
    logic [7:0]    payload_mem [MAX_PAYLOAD];

    initial
    begin
        foreach (payload_mem[i])
            payload_mem[i] = 8'h00;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // reflected CRC-8, poly 0x8C, LSB first
    function automatic logic [7:0] crc8_maxim_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] acc;
        acc = crc ^ b;
        repeat (8)
            acc = {1'b0, acc[7:1]} ^ (acc[0] ? CRC_POLY : 8'h00);
        return acc;
    endfunction

    // length register saturates at the payload store depth
    function automatic int unsigned payload_len_now();
        return (len_reg > MAX_PAYLOAD) ? MAX_PAYLOAD : len_reg;
    endfunction

    // advance the frame decoder by one accepted byte; queue the results of a
    // completed frame
    task automatic decode_byte(input logic [7:0] b, input logic restart);
        int unsigned   n;
        status_t       st;
        frame_result_t r;
        n = payload_len_now();
        if (restart)
        begin
            frame_pos = 0;
            frame_crc = 8'h00;
        end
        // checksum byte is stored but kept out of the CRC
        if (frame_pos == POS_CHECKSUM)
            sum_byte = b;
        else
        begin
            if (frame_pos == POS_LENGTH)
                len_byte = b;
            else if (frame_pos == POS_COMMAND)
                cmd_byte = b;
            else if (frame_pos >= FRAME_OVERHEAD && frame_pos - FRAME_OVERHEAD < MAX_PAYLOAD)
                payload_mem[frame_pos - FRAME_OVERHEAD] = b;
            frame_crc = crc8_maxim_step(frame_crc, b);
        end
        // frame not done yet (also covers a length change mid-frame)
        if (frame_pos + 1 < n + FRAME_OVERHEAD)
        begin
            frame_pos++;
            return;
        end
        if (n > 0)
        begin
            if (sum_byte != frame_crc)
                st = STATUS_CHECKSUM;
            else if (cmd_byte == unsup_reg)
                st = STATUS_UNSUPPORTED;
            else if (len_byte != n)
                st = STATUS_LENGTH;
            else
                st = STATUS_OK;
        end
        else
        begin
            // acknowledge frame: first matching code wins
            if (sum_byte != frame_crc || len_byte != 8'h00)
                st = STATUS_CHECKSUM;
            else if (cmd_byte == confl_reg)
                st = STATUS_CONFLICT;
            else if (cmd_byte == unsup_reg)
                st = STATUS_UNSUPPORTED;
            else if (cmd_byte == badpar_reg)
                st = STATUS_BAD_PARAM;
            else
                st = STATUS_OK;
        end
        frame_pos = 0;
        frame_crc = 8'h00;
        r.command = cmd_byte;
        r.status  = st;
        if (n == 0)
        begin
            r.payload     = 8'h00;
            r.index       = '0;
            r.has_payload = 1'b0;
            r.last        = 1'b1;
            results_due.push_back(r);
        end
        else
        begin
            for (int k = 0; k < n; k++)
            begin
                r.payload     = payload_mem[k];
                r.index       = k[IDX_W-1:0];
                r.has_payload = 1'b1;
                r.last        = (k + 1 == n);
                results_due.push_back(r);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic flag_error(input string msg);
        $display("tb_top: mismatch: %s", msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            flag_error($sformatf("%s got %0d want %0d (%0d still due)",
                                 name, got, want, results_due.size()));
    endtask

    task automatic check_result();
        frame_result_t want;
        if (results_due.size() == 0)
        begin
            flag_error($sformatf("result with nothing due, tdata %h", m_tdata));
            return;
        end
        want = results_due.pop_front();
        check_field("command",      m_tdata[7:0],   want.command);
        check_field("status",       m_tdata[10:8],  want.status);
        check_field("payload_byte", m_tdata[18:11], want.payload);
        check_field("byte_index",   m_tdata[22:19], want.index);
        check_field("has_payload",  m_tuser,        want.has_payload);
        check_field("last",         m_tlast,        want.last);
    endtask

    // ------------------------------------------------------------------
    // input driver: one byte request per handshake, random gap after each
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            // predict on the accepted byte; taken count moves with it
            if (s_tvalid && s_tready)
            begin
                decode_byte(s_tdata, s_tuser);
                bytes_taken++;
            end
            // slot is free: either idle out the gap or present the next byte
            if (!s_tvalid || s_tready)
            begin
                if (tx_wait > 0 || byte_queue.size() == 0)
                begin
                    if (tx_wait > 0)
                        tx_wait--;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    next_req = byte_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_req.data;
                    s_tuser  <= next_req.restart;
                    tx_wait  = $urandom_range(0, tx_idle_max);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output monitor: checks each result request, random gap after each
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_result();
                rx_wait = $urandom_range(0, rx_idle_max);
            end
            if (rx_stall || rx_wait > 0)
            begin
                if (rx_wait > 0)
                    rx_wait--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // long hold-off on the output while the sender keeps pushing bytes,
    // so the result buffer fills and s_tready drops
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        rx_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_stall <= 1'b0;
    end

    // hard stop
    initial
    begin
        #(TIMEOUT_UNITS);
        $display("tb_top: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic restart);
        rx_request_t r;
        r.data    = b;
        r.restart = restart;
        byte_queue.push_back(r);
        bytes_queued++;
    endtask

    // build a frame for the current length with a correct CRC unless told
    // otherwise; only the first 'keep' bytes are sent
    task automatic queue_frame_fields(input logic [7:0] lenb, input logic [7:0] cmd,
                                      input logic bad_sum, input logic lead_restart,
                                      input int unsigned keep);
        int unsigned n;
        logic [7:0]  crc;
        logic [7:0]  b;
        logic [7:0]  frame [$];
        n = payload_len_now();
        b = 8'($urandom);
        frame.push_back(b);
        crc = crc8_maxim_step(8'h00, b);
        frame.push_back(lenb);
        crc = crc8_maxim_step(crc, lenb);
        frame.push_back(cmd);
        crc = crc8_maxim_step(crc, cmd);
        frame.push_back(8'h00);                 // checksum slot, filled below
        for (int k = 0; k < n; k++)
        begin
            b = 8'($urandom);
            frame.push_back(b);
            crc = crc8_maxim_step(crc, b);
        end
        frame[3] = bad_sum ? (crc ^ (8'h01 << $urandom_range(0, 7))) : crc;
        for (int k = 0; k < keep && k < frame.size(); k++)
            push_byte(frame[k], (k == 0) ? lead_restart : 1'b0);
    endtask

    // commands hit the special codes often
    function automatic logic [7:0] pick_command();
        case ($urandom_range(0, 5))
            0:       return unsup_reg;
            1:       return confl_reg;
            2:       return badpar_reg;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_frame(input frame_kind_t kind);
        int unsigned n;
        n = payload_len_now();
        case (kind)
            FRAME_GOOD:
                queue_frame_fields(8'(n), pick_command(), 1'b0,
                                   $urandom_range(0, 4) != 0, n + FRAME_OVERHEAD);
            FRAME_BAD_SUM:
                queue_frame_fields(8'(n), pick_command(), 1'b1, 1'b1, n + FRAME_OVERHEAD);
            FRAME_BAD_LEN:
                queue_frame_fields(8'(n) ^ (8'h01 << $urandom_range(0, 7)), pick_command(),
                                   1'b0, 1'b1, n + FRAME_OVERHEAD);
            FRAME_CUT:
                queue_frame_fields(8'(n), pick_command(), 1'b0, 1'b1,
                                   $urandom_range(1, n + FRAME_OVERHEAD - 1));
            default:
                repeat ($urandom_range(1, 6))
                    push_byte(8'($urandom), 1'($urandom_range(0, 1)));
        endcase
    endtask

    // idle means every byte taken and every result seen, plus the pipeline
    // latency in case the last bytes left a frame open
    task automatic wait_idle();
        while (bytes_taken != bytes_queued || results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_PAYLOAD_LEN: len_reg    = val[4:0];
            REG_UNSUPPORTED: unsup_reg  = val;
            REG_CONFLICT:    confl_reg  = val;
            default:         badpar_reg = val;
        endcase
    endtask

    // one phase: settle, program all registers, then random frames
    task automatic run_phase(input logic [4:0] len, input logic [7:0] unsup,
                             input logic [7:0] confl, input logic [7:0] badpar,
                             input int tx_max, input int rx_max, input int unsigned nbytes);
        int unsigned start;
        int          r;
        wait_idle();
        write_reg(REG_PAYLOAD_LEN, CFG_W'(len));
        write_reg(REG_UNSUPPORTED, unsup);
        write_reg(REG_CONFLICT, confl);
        write_reg(REG_BAD_PARAM, badpar);
        tx_idle_max = tx_max;
        rx_idle_max = rx_max;
        start = bytes_queued;
        while (bytes_queued - start < nbytes)
        begin
            r = $urandom_range(0, 9);
            queue_frame((r < 6) ? FRAME_GOOD : frame_kind_t'(r - 5));
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset registers (L = 0, codes 1/2/3), every ack status
        tx_idle_max = 2;
        rx_idle_max = 2;
        queue_frame_fields(8'h00, 8'h00, 1'b0, 1'b0, 4);   // ok, no restart after reset
        queue_frame_fields(8'h00, 8'hFF, 1'b1, 1'b1, 4);   // bad checksum
        queue_frame_fields(8'h01, 8'h55, 1'b0, 1'b1, 4);   // nonzero length byte
        queue_frame_fields(8'h00, 8'h02, 1'b0, 1'b1, 4);   // motion conflict
        queue_frame_fields(8'h00, 8'h01, 1'b0, 1'b0, 4);   // unsupported
        queue_frame_fields(8'h00, 8'h03, 1'b0, 1'b1, 4);   // parameter error

        run_phase(5'd1, 8'h10, 8'h20, 8'h30, 3, 3, 40);
        run_phase(5'd16, 8'($urandom), 8'($urandom), 8'($urandom), 10, 0, 40);
        // leave a long frame half done, then shrink L: it ends on the next byte unless that is a restart
        queue_frame_fields(8'd16, 8'h42, 1'b0, 1'b1, 9);
        // all three codes equal: conflict wins
        run_phase(5'd0, 8'h7E, 8'h7E, 8'h7E, 0, 10, 40);
        // open an ack frame, then grow L past the store depth (saturates)
        queue_frame_fields(8'h00, 8'h11, 1'b0, 1'b1, 2);
        wait_idle();
        hold_go = 1'b1;
        run_phase(5'd31, 8'h00, 8'hFF, 8'h00, 0, 0, 50);
        run_phase(5'd2, 8'hFF, 8'h00, 8'hFF, 10, 10, 40);
        run_phase(5'($urandom_range(0, 16)), 8'($urandom), 8'($urandom), 8'($urandom),
                  5, 5, 50);
        run_phase(5'd17, 8'd1, 8'd2, 8'd3, 2, 2, 30);

        wait_idle();
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

`default_nettype wire
